FILE: hdl/rsbp_pkg.sv
// Shared types, constants and helpers for the RGBA5551 scissor/blend pixel stage.
// No dependencies; used by every module under hdl/.
package rsbp_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int PIX_W      = 16;
    localparam int ALPHA_W    = 8;
    localparam int FIELD_W    = 5;
    localparam int NUM_FIELDS = 3;
    localparam int DIFF_W     = PIX_W + 1;
    localparam int PROD_W     = DIFF_W + ALPHA_W + 1;
    localparam int LERP_SHIFT = 8;
    localparam int DARK_W     = 3;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_COLOR     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCISSOR_LEFT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCISSOR_TOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCISSOR_RIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCISSOR_BOTTOM = 3'd4;

    localparam logic [CFG_DATA_W-1:0] RST_FILL_COLOR = 32'h0000_00FF;
    localparam int RST_SCISSOR_RIGHT  = 320;
    localparam int RST_SCISSOR_BOTTOM = 240;

    // Alpha codes that select a darken level for a black fill
    localparam logic [ALPHA_W-1:0] ALPHA_DARK1  = 8'h7F;
    localparam logic [ALPHA_W-1:0] ALPHA_DARK2  = 8'hBF;
    localparam logic [ALPHA_W-1:0] ALPHA_DARK3  = 8'hDF;
    localparam logic [ALPHA_W-1:0] ALPHA_DARK4  = 8'hEF;
    localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [ALPHA_W-1:0] ALPHA_CLEAR  = 8'h00;

    typedef enum logic [1:0] {
        OP_KEEP   = 2'd0,
        OP_DARKEN = 2'd1,
        OP_FILL   = 2'd2,
        OP_LERP   = 2'd3
    } t_op;

    typedef struct packed {
        logic              we;
        t_op               op;
        logic [DARK_W-1:0] k;
        logic [PIX_W-1:0]  dst;
        logic [PIX_W-1:0]  col;
    } t_ctrl;

    // RRGGBBAA -> RRRRRGGGGGBBBBB1
    function automatic logic [PIX_W-1:0] to_5551(input logic [CFG_DATA_W-1:0] c);
        return {c[31:27], c[23:19], c[15:11], 1'b1};
    endfunction

    // Field i: 0 = blue (bits 5:1), 1 = green (10:6), 2 = red (15:11)
    function automatic logic [PIX_W-1:0] field_mask(input int i);
        logic [PIX_W-1:0] m;
        m = PIX_W'(5'h1F) << (1 + FIELD_W * i);
        return m;
    endfunction

endpackage

FILE: hdl/rsbp_front.sv
// First pipeline stage: scissor test, write decision, darken level and the
// signed per-field differences for the blend. Depends on rsbp_pkg.
module rsbp_front #(
    parameter int COORD_BITS = 10
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [COORD_BITS-1:0]                 i_pixel_x,
    input  logic [COORD_BITS-1:0]                 i_pixel_y,
    input  logic [rsbp_pkg::PIX_W-1:0]            i_dst_pixel,
    input  logic                                  i_covered,
    input  logic [rsbp_pkg::CFG_DATA_W-1:0]       i_fill_color,
    input  logic [COORD_BITS:0]                   i_scissor_left,
    input  logic [COORD_BITS:0]                   i_scissor_top,
    input  logic [COORD_BITS:0]                   i_scissor_right,
    input  logic [COORD_BITS:0]                   i_scissor_bottom,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output rsbp_pkg::t_ctrl                       o_ctrl,
    output logic [rsbp_pkg::ALPHA_W-1:0]          o_alpha,
    output logic [rsbp_pkg::NUM_FIELDS-1:0][rsbp_pkg::DIFF_W-1:0] o_diff
);

    logic                                  r_valid;
    rsbp_pkg::t_ctrl                       r_ctrl;
    rsbp_pkg::t_ctrl                       n_ctrl;
    logic [rsbp_pkg::ALPHA_W-1:0]          r_alpha;
    logic [rsbp_pkg::ALPHA_W-1:0]          alpha;
    logic [rsbp_pkg::NUM_FIELDS-1:0][rsbp_pkg::DIFF_W-1:0] r_diff;
    logic [rsbp_pkg::NUM_FIELDS-1:0][rsbp_pkg::DIFF_W-1:0] n_diff;
    logic                                  in_box;
    logic                                  black;
    logic [rsbp_pkg::DARK_W-1:0]           k;
    logic [rsbp_pkg::PIX_W-1:0]            col;
    logic [rsbp_pkg::PIX_W-1:0]            m;

    always_comb begin
        alpha  = i_fill_color[rsbp_pkg::ALPHA_W-1:0];
        col    = rsbp_pkg::to_5551(i_fill_color);
        black  = (col[rsbp_pkg::PIX_W-1:1] == '0);
        in_box = ({1'b0, i_pixel_x} >= i_scissor_left) &&
                 ({1'b0, i_pixel_y} >= i_scissor_top) &&
                 ({1'b0, i_pixel_x} <  i_scissor_right) &&
                 ({1'b0, i_pixel_y} <  i_scissor_bottom);

        case (alpha)
            rsbp_pkg::ALPHA_DARK1:  k = 3'd1;
            rsbp_pkg::ALPHA_DARK2:  k = 3'd2;
            rsbp_pkg::ALPHA_DARK3:  k = 3'd3;
            rsbp_pkg::ALPHA_DARK4:  k = 3'd4;
            rsbp_pkg::ALPHA_OPAQUE: k = 3'd5;
            default:                k = 3'd0;
        endcase

        n_ctrl.we  = i_covered && in_box && (alpha != rsbp_pkg::ALPHA_CLEAR);
        n_ctrl.k   = k;
        n_ctrl.dst = i_dst_pixel;
        n_ctrl.col = col;
        if (!n_ctrl.we) begin
            n_ctrl.op = rsbp_pkg::OP_KEEP;
        end else if (black && (k != '0)) begin
            n_ctrl.op = rsbp_pkg::OP_DARKEN;
        end else if (alpha == rsbp_pkg::ALPHA_OPAQUE) begin
            n_ctrl.op = rsbp_pkg::OP_FILL;
        end else begin
            n_ctrl.op = rsbp_pkg::OP_LERP;
        end

        // Differences stay at the field's bit position, as the blend math expects
        for (int i = 0; i < rsbp_pkg::NUM_FIELDS; i++) begin
            m = rsbp_pkg::field_mask(i);
            n_diff[i] = {1'b0, col & m} - {1'b0, i_dst_pixel & m};
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ctrl  <= n_ctrl;
            r_alpha <= alpha;
            r_diff  <= n_diff;
        end
    end

    assign o_valid = r_valid;
    assign o_ctrl  = r_ctrl;
    assign o_alpha = r_alpha;
    assign o_diff  = r_diff;

endmodule

FILE: hdl/rsbp_mul.sv
// Second pipeline stage: alpha times each signed field difference.
// Depends on rsbp_pkg.
module rsbp_mul (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  rsbp_pkg::t_ctrl                       i_ctrl,
    input  logic [rsbp_pkg::ALPHA_W-1:0]          i_alpha,
    input  logic [rsbp_pkg::NUM_FIELDS-1:0][rsbp_pkg::DIFF_W-1:0] i_diff,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output rsbp_pkg::t_ctrl                       o_ctrl,
    output logic [rsbp_pkg::NUM_FIELDS-1:0][rsbp_pkg::PROD_W-1:0] o_prod
);

    logic                                  r_valid;
    rsbp_pkg::t_ctrl                       r_ctrl;
    logic [rsbp_pkg::NUM_FIELDS-1:0][rsbp_pkg::PROD_W-1:0] r_prod;
    logic [rsbp_pkg::NUM_FIELDS-1:0][rsbp_pkg::PROD_W-1:0] n_prod;

    always_comb begin
        for (int i = 0; i < rsbp_pkg::NUM_FIELDS; i++) begin
            n_prod[i] = rsbp_pkg::PROD_W'($signed({1'b0, i_alpha}) * $signed(i_diff[i]));
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ctrl <= i_ctrl;
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_valid;
    assign o_ctrl  = r_ctrl;
    assign o_prod  = r_prod;

endmodule

FILE: hdl/rsbp_back.sv
// Third pipeline stage and output register: lerp finish (floor shift, add, mask),
// darken shift and final pixel select. Depends on rsbp_pkg.
module rsbp_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  rsbp_pkg::t_ctrl                       i_ctrl,
    input  logic [rsbp_pkg::NUM_FIELDS-1:0][rsbp_pkg::PROD_W-1:0] i_prod,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [rsbp_pkg::PIX_W-1:0]            o_new_pixel,
    output logic                                  o_write_enable
);

    logic                                  r_valid;
    logic [rsbp_pkg::PIX_W-1:0]            r_new_pixel;
    logic                                  r_write_enable;
    logic [rsbp_pkg::PIX_W-1:0]            n_new_pixel;
    logic [rsbp_pkg::PIX_W-1:0]            lerp_px;
    logic [rsbp_pkg::PIX_W-1:0]            dark_px;
    logic [rsbp_pkg::PIX_W-1:0]            m;
    logic signed [rsbp_pkg::PROD_W-1:0]    sum;
    logic [rsbp_pkg::PIX_W-1:0]            dst;

    always_comb begin
        dst     = i_ctrl.dst;
        lerp_px = rsbp_pkg::PIX_W'(1);
        for (int i = 0; i < rsbp_pkg::NUM_FIELDS; i++) begin
            m   = rsbp_pkg::field_mask(i);
            // arithmetic shift gives floor division for negative products
            sum = ($signed(i_prod[i]) >>> rsbp_pkg::LERP_SHIFT) +
                  $signed(rsbp_pkg::PROD_W'(dst & m));
            lerp_px = lerp_px | (sum[rsbp_pkg::PIX_W-1:0] & m);
        end

        dark_px = {dst[15:11] >> i_ctrl.k, dst[10:6] >> i_ctrl.k,
                   dst[5:1] >> i_ctrl.k, 1'b1};

        case (i_ctrl.op)
            rsbp_pkg::OP_DARKEN: n_new_pixel = dark_px;
            rsbp_pkg::OP_FILL:   n_new_pixel = i_ctrl.col;
            rsbp_pkg::OP_LERP:   n_new_pixel = lerp_px;
            default:             n_new_pixel = dst;
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_new_pixel    <= n_new_pixel;
            r_write_enable <= i_ctrl.we;
        end
    end

    assign o_valid        = r_valid;
    assign o_new_pixel    = r_new_pixel;
    assign o_write_enable = r_write_enable;

endmodule

FILE: hdl/rgba5551_scissor_blend_pixel.sv
// Top level of the RGBA5551 scissor/blend pixel write stage.
// Depends on rsbp_pkg, rsbp_front, rsbp_mul and rsbp_back.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one transaction per pixel:
//   coordinate, current framebuffer pixel and a coverage bit. Output channel
//   (o_out_valid / i_out_ready) returns the pixel to store and its write enable.
//   Configuration: a write at any clock with i_cfg_we high; index 0 is the
//   RRGGBBAA fill color, 1..4 the scissor box left, top, right (exclusive) and
//   bottom (exclusive). Unknown indexes are dropped. Write only while idle.
//   Pipeline: an accepted input is registered in the front stage, then the alpha
//   multiply stage, then blend/select into the output register (o_out_valid).
//   Throughput: one transaction per cycle while i_out_ready stays high; each
//   stage holds one transaction, so up to three are in flight.
//   Stall: when i_out_ready is low the output register holds; earlier stages keep
//   filling their empty slots, then o_in_ready drops. Nothing is lost or repeated.
//   Reset (synchronous, active low): pipeline emptied, fill color 0x000000FF,
//   scissor box 0,0 to 320,240.
module rgba5551_scissor_blend_pixel #(
    parameter int COORD_BITS = 10
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [rsbp_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [rsbp_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [COORD_BITS-1:0]                 i_pixel_x,
    input  logic [COORD_BITS-1:0]                 i_pixel_y,
    input  logic [rsbp_pkg::PIX_W-1:0]            i_dst_pixel,
    input  logic                                  i_covered,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [rsbp_pkg::PIX_W-1:0]            o_new_pixel,
    output logic                                  o_write_enable
);

    localparam int SC_W = COORD_BITS + 1;

    logic [rsbp_pkg::CFG_DATA_W-1:0] r_fill_color;
    logic [SC_W-1:0]                 r_scissor_left;
    logic [SC_W-1:0]                 r_scissor_top;
    logic [SC_W-1:0]                 r_scissor_right;
    logic [SC_W-1:0]                 r_scissor_bottom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_color     <= rsbp_pkg::RST_FILL_COLOR;
            r_scissor_left   <= '0;
            r_scissor_top    <= '0;
            r_scissor_right  <= SC_W'(rsbp_pkg::RST_SCISSOR_RIGHT);
            r_scissor_bottom <= SC_W'(rsbp_pkg::RST_SCISSOR_BOTTOM);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rsbp_pkg::CFG_FILL_COLOR:     r_fill_color     <= i_cfg_data;
                rsbp_pkg::CFG_SCISSOR_LEFT:   r_scissor_left   <= i_cfg_data[SC_W-1:0];
                rsbp_pkg::CFG_SCISSOR_TOP:    r_scissor_top    <= i_cfg_data[SC_W-1:0];
                rsbp_pkg::CFG_SCISSOR_RIGHT:  r_scissor_right  <= i_cfg_data[SC_W-1:0];
                rsbp_pkg::CFG_SCISSOR_BOTTOM: r_scissor_bottom <= i_cfg_data[SC_W-1:0];
                default: ;
            endcase
        end
    end

    logic                                  s1_valid;
    logic                                  s1_ready;
    rsbp_pkg::t_ctrl                       s1_ctrl;
    logic [rsbp_pkg::ALPHA_W-1:0]          s1_alpha;
    logic [rsbp_pkg::NUM_FIELDS-1:0][rsbp_pkg::DIFF_W-1:0] s1_diff;
    logic                                  s2_valid;
    logic                                  s2_ready;
    rsbp_pkg::t_ctrl                       s2_ctrl;
    logic [rsbp_pkg::NUM_FIELDS-1:0][rsbp_pkg::PROD_W-1:0] s2_prod;

    rsbp_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_in_valid),
        .o_ready         (o_in_ready),
        .i_pixel_x       (i_pixel_x),
        .i_pixel_y       (i_pixel_y),
        .i_dst_pixel     (i_dst_pixel),
        .i_covered       (i_covered),
        .i_fill_color    (r_fill_color),
        .i_scissor_left  (r_scissor_left),
        .i_scissor_top   (r_scissor_top),
        .i_scissor_right (r_scissor_right),
        .i_scissor_bottom(r_scissor_bottom),
        .o_valid         (s1_valid),
        .i_ready         (s1_ready),
        .o_ctrl          (s1_ctrl),
        .o_alpha         (s1_alpha),
        .o_diff          (s1_diff)
    );

    rsbp_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(s1_valid),
        .o_ready(s1_ready),
        .i_ctrl (s1_ctrl),
        .i_alpha(s1_alpha),
        .i_diff (s1_diff),
        .o_valid(s2_valid),
        .i_ready(s2_ready),
        .o_ctrl (s2_ctrl),
        .o_prod (s2_prod)
    );

    rsbp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s2_valid),
        .o_ready       (s2_ready),
        .i_ctrl        (s2_ctrl),
        .i_prod        (s2_prod),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_new_pixel   (o_new_pixel),
        .o_write_enable(o_write_enable)
    );

endmodule

FILE: hdl/rsbp_checker.sv
// Port-level checker for rgba5551_scissor_blend_pixel, bound to the top level.
// Depends on rsbp_pkg.
module rsbp_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  o_in_ready,
    input logic                                  o_out_valid,
    input logic                                  i_out_ready,
    input logic [rsbp_pkg::PIX_W-1:0]            o_new_pixel,
    input logic                                  o_write_enable
);

    // A stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_new_pixel) && $stable(o_write_enable))
        else $error("result changed or dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // Every written pixel carries alpha bit set
    a_alpha_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_write_enable |-> o_new_pixel[0])
        else $error("written pixel without alpha bit");

    // With a free-running receiver an accepted transaction reaches the output register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) ##1 i_out_ready ##1 i_out_ready |=> o_out_valid)
        else $error("transaction did not reach the output in three cycles");

    // An empty output register means the whole pipe can take a transaction
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

endmodule

bind rgba5551_scissor_blend_pixel rsbp_checker u_rsbp_checker (.*);

FILE: sim/tb.sv
// Self-checking testbench for the RGBA5551 scissor/blend pixel write stage.
// Depends on rsbp_pkg and rgba5551_scissor_blend_pixel; runs a directed table, then random pixels.
// Every accepted pixel is predicted in the bench and compared with the block's output in order.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS = 10;
    localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
    localparam int SCI_W      = COORD_BITS + 1;
    localparam int N_DIRECTED = 25;
    localparam int GROUPS     = 17;
    localparam int GROUP_LEN  = 30;

    typedef struct packed {
        logic [31:0] fill;
        logic [31:0] left;
        logic [31:0] top;
        logic [31:0] right;
        logic [31:0] bottom;
    } t_draw_setting;

    typedef struct packed {
        logic [rsbp_pkg::PIX_W-1:0] pixel;
        logic                       we;
    } t_pixel_write;

    typedef struct packed {
        t_draw_setting              setup;
        logic [COORD_BITS-1:0]      x;
        logic [COORD_BITS-1:0]      y;
        logic [rsbp_pkg::PIX_W-1:0] dst;
        logic                       cov;
        logic                       known;
        logic [rsbp_pkg::PIX_W-1:0] exp_pixel;
        logic                       exp_we;
    } t_dir_row;

    localparam t_draw_setting RESET_SETTING =
        '{rsbp_pkg::RST_FILL_COLOR, 0, 0, rsbp_pkg::RST_SCISSOR_RIGHT,
          rsbp_pkg::RST_SCISSOR_BOTTOM};

    // Rows with known = 1 carry a hand-written expectation; the rest go through the predictor.
    localparam t_dir_row DIRECTED [N_DIRECTED] = '{
        '{RESET_SETTING, 10'd0, 10'd0, 16'hFFFF, 1'b1, 1'b1, 16'h0001, 1'b1},
        '{RESET_SETTING, 10'd319, 10'd239, 16'hABCD, 1'b1, 1'b1, 16'h0001, 1'b1},
        '{RESET_SETTING, 10'd320, 10'd0, 16'h1234, 1'b1, 1'b1, 16'h1234, 1'b0},
        '{RESET_SETTING, 10'd0, 10'd240, 16'h4321, 1'b1, 1'b1, 16'h4321, 1'b0},
        '{RESET_SETTING, 10'd10, 10'd10, 16'h5555, 1'b0, 1'b1, 16'h5555, 1'b0},
        '{RESET_SETTING, 10'd1023, 10'd1023, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF, 1'b0},
        // black fill, darken codes
        '{'{32'h0000_007F, 0, 0, 320, 240}, 10'd5, 10'd5, 16'hFFFF, 1'b1, 1'b0, 16'h0, 1'b0},
        '{'{32'h0000_00BF, 0, 0, 320, 240}, 10'd6, 10'd6, 16'hFFFF, 1'b1, 1'b0, 16'h0, 1'b0},
        '{'{32'h0000_00DF, 0, 0, 320, 240}, 10'd7, 10'd7, 16'h8421, 1'b1, 1'b0, 16'h0, 1'b0},
        '{'{32'h0000_00EF, 0, 0, 320, 240}, 10'd8, 10'd8, 16'hFFFF, 1'b1, 1'b0, 16'h0, 1'b0},
        // black but not a darken code: plain lerp
        '{'{32'h0000_0080, 0, 0, 320, 240}, 10'd9, 10'd9, 16'hFFFF, 1'b1, 1'b0, 16'h0, 1'b0},
        // low channel bits vanish in the 5551 reduction, so this is still black
        '{'{32'h0707_07FF, 0, 0, 320, 240}, 10'd11, 10'd11, 16'hFFFF, 1'b1, 1'b1, 16'h0001, 1'b1},
        '{'{32'hFFFF_FF00, 0, 0, 320, 240}, 10'd12, 10'd12, 16'h0F0F, 1'b1, 1'b1, 16'h0F0F, 1'b0},
        '{'{32'hFFFF_FFFF, 0, 0, 320, 240}, 10'd13, 10'd13, 16'h0000, 1'b1, 1'b1, 16'hFFFF, 1'b1},
        '{'{32'hFF00_0080, 0, 0, 320, 240}, 10'd14, 10'd14, 16'h0000, 1'b1, 1'b0, 16'h0, 1'b0},
        '{'{32'h00FF_0001, 0, 0, 320, 240}, 10'd15, 10'd15, 16'hFFFF, 1'b1, 1'b0, 16'h0, 1'b0},
        '{'{32'h1234_56FE, 0, 0, 320, 240}, 10'd16, 10'd16, 16'h8421, 1'b1, 1'b0, 16'h0, 1'b0},
        // one-pixel box, then its neighbors
        '{'{32'hFFFF_FFFF, 100, 50, 101, 51}, 10'd100, 10'd50, 16'h0000, 1'b1, 1'b1, 16'hFFFF, 1'b1},
        '{'{32'hFFFF_FFFF, 100, 50, 101, 51}, 10'd99, 10'd50, 16'h0000, 1'b1, 1'b1, 16'h0000, 1'b0},
        '{'{32'hFFFF_FFFF, 100, 50, 101, 51}, 10'd100, 10'd51, 16'h7777, 1'b1, 1'b1, 16'h7777, 1'b0},
        // empty box
        '{'{32'hFFFF_FFFF, 200, 0, 200, 240}, 10'd200, 10'd5, 16'h1111, 1'b1, 1'b1, 16'h1111, 1'b0},
        '{'{32'hFFFF_FFFF, 0, 0, 1024, 1024}, 10'd1023, 10'd1023, 16'h2222, 1'b1, 1'b1, 16'hFFFF, 1'b1},
        // upper data bits dropped: right/bottom become 2047, then bottom 0x800 becomes 0
        '{'{32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 10'd1023, 10'd1023, 16'h3333,
          1'b1, 1'b1, 16'hFFFF, 1'b1},
        '{'{32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF, 32'h0000_0800}, 10'd1023, 10'd0, 16'h4444,
          1'b1, 1'b1, 16'h4444, 1'b0},
        '{'{32'hFFFF_FFFF, 1024, 1024, 1024, 1024}, 10'd1023, 10'd1023, 16'h5555,
          1'b1, 1'b1, 16'h5555, 1'b0}
    };

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [rsbp_pkg::CFG_IDX_W-1:0]  i_cfg_idx = rsbp_pkg::CFG_FILL_COLOR;
    logic [rsbp_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_ready;
    logic [COORD_BITS-1:0]           i_pixel_x = '0;
    logic [COORD_BITS-1:0]           i_pixel_y = '0;
    logic [rsbp_pkg::PIX_W-1:0]      i_dst_pixel = '0;
    logic                            i_covered = 1'b0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    logic [rsbp_pkg::PIX_W-1:0]      o_new_pixel;
    logic                            o_write_enable;

    // shadow copy of the block's registers, updated on the same edge as the block
    logic [rsbp_pkg::CFG_DATA_W-1:0] sh_fill;
    logic [SCI_W-1:0]                sh_left, sh_top, sh_right, sh_bottom;

    t_draw_setting  cur_setting = RESET_SETTING;
    t_pixel_write   pending_pixels [$];
    logic           exp_known = 1'b0;
    t_pixel_write   exp_typed = '0;
    int             src_idle_pct = 20;
    int             sink_idle_pct = 77;
    int             n_sent = 0;
    int             n_done = 0;
    int             n_written = 0;
    int             n_settings = 0;
    int             n_errors = 0;

    rgba5551_scissor_blend_pixel #(
        .COORD_BITS(COORD_BITS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .i_dst_pixel    (i_dst_pixel),
        .i_covered      (i_covered),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_new_pixel    (o_new_pixel),
        .o_write_enable (o_write_enable)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Expected pixel for one transaction under the shadow registers
    function automatic t_pixel_write blend_pixel(input logic [COORD_BITS-1:0] x,
                                                 input logic [COORD_BITS-1:0] y,
                                                 input logic [rsbp_pkg::PIX_W-1:0] dst,
                                                 input logic cov);
        logic [rsbp_pkg::ALPHA_W-1:0] a;
        logic [rsbp_pkg::PIX_W-1:0]   col, mask, s;
        logic [rsbp_pkg::FIELD_W-1:0] ch;
        logic                         in_box;
        int                           k, ds, diff, prod;
        t_pixel_write                 r;
        a = sh_fill[rsbp_pkg::ALPHA_W-1:0];
        col = {sh_fill[31:27], sh_fill[23:19], sh_fill[15:11], 1'b1};
        in_box = {1'b0, x} >= sh_left && {1'b0, y} >= sh_top &&
                 {1'b0, x} < sh_right && {1'b0, y} < sh_bottom;
        r.we = cov && in_box && a != rsbp_pkg::ALPHA_CLEAR;
        r.pixel = dst;
        k = 0;
        if (col == 16'h0001) begin
            case (a)
                rsbp_pkg::ALPHA_DARK1:  k = 1;
                rsbp_pkg::ALPHA_DARK2:  k = 2;
                rsbp_pkg::ALPHA_DARK3:  k = 3;
                rsbp_pkg::ALPHA_DARK4:  k = 4;
                rsbp_pkg::ALPHA_OPAQUE: k = 5;
                default:                k = 0;
            endcase
        end
        if (r.we) begin
            if (k != 0) begin
                ch = 5'h1F << k;
                mask = {ch, ch, ch, 1'b0};
                r.pixel = ((dst & mask) >> k) | 16'h0001;
            end else if (a == rsbp_pkg::ALPHA_OPAQUE) begin
                r.pixel = col;
            end else begin
                r.pixel = 16'h0001;
                for (int f = 0; f < rsbp_pkg::NUM_FIELDS; f++) begin
                    s = 16'h001F << (1 + rsbp_pkg::FIELD_W * f);
                    ds = int'(dst & s);
                    diff = int'(col & s) - ds;
                    prod = int'(a) * diff;
                    // arithmetic shift floors negative products
                    r.pixel = r.pixel |
                              (rsbp_pkg::PIX_W'((prod >>> rsbp_pkg::LERP_SHIFT) + ds) & s);
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_pixel_write got, want;
        if (!i_rst_n) begin
            sh_fill   = RESET_SETTING.fill;
            sh_left   = SCI_W'(RESET_SETTING.left);
            sh_top    = SCI_W'(RESET_SETTING.top);
            sh_right  = SCI_W'(RESET_SETTING.right);
            sh_bottom = SCI_W'(RESET_SETTING.bottom);
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rsbp_pkg::CFG_FILL_COLOR:     sh_fill = i_cfg_data;
                    rsbp_pkg::CFG_SCISSOR_LEFT:   sh_left = i_cfg_data[SCI_W-1:0];
                    rsbp_pkg::CFG_SCISSOR_TOP:    sh_top = i_cfg_data[SCI_W-1:0];
                    rsbp_pkg::CFG_SCISSOR_RIGHT:  sh_right = i_cfg_data[SCI_W-1:0];
                    rsbp_pkg::CFG_SCISSOR_BOTTOM: sh_bottom = i_cfg_data[SCI_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                if (exp_known)
                    pending_pixels.push_back(exp_typed);
                else
                    pending_pixels.push_back(blend_pixel(i_pixel_x, i_pixel_y, i_dst_pixel,
                                                         i_covered));
            end
            if (o_out_valid && i_out_ready) begin
                got = '{o_new_pixel, o_write_enable};
                n_done++;
                if (got.we === 1'b1)
                    n_written++;
                if (pending_pixels.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("ERROR: output with nothing pending: pixel=%h we=%b",
                                 got.pixel, got.we);
                end else begin
                    want = pending_pixels.pop_front();
                    if (got.pixel !== want.pixel || got.we !== want.we) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("ERROR: transaction %0d: pixel exp %h got %h, we exp %b got %b",
                                     n_done, want.pixel, got.pixel, want.we, got.we);
                    end
                end
            end
        end
    end

    task automatic wait_drained();
        while (n_done != n_sent)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [rsbp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rsbp_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Registers only change with the pipeline empty
    task automatic program_setting(input t_draw_setting s);
        if (s == cur_setting)
            return;
        // the last transaction is already taken; stop offering it
        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait_drained();
        if (s.fill !== cur_setting.fill)
            write_reg(rsbp_pkg::CFG_FILL_COLOR, s.fill);
        if (s.left !== cur_setting.left)
            write_reg(rsbp_pkg::CFG_SCISSOR_LEFT, s.left);
        if (s.top !== cur_setting.top)
            write_reg(rsbp_pkg::CFG_SCISSOR_TOP, s.top);
        if (s.right !== cur_setting.right)
            write_reg(rsbp_pkg::CFG_SCISSOR_RIGHT, s.right);
        if (s.bottom !== cur_setting.bottom)
            write_reg(rsbp_pkg::CFG_SCISSOR_BOTTOM, s.bottom);
        // unused indexes must be dropped
        if (n_settings % 4 == 0)
            write_reg(rsbp_pkg::CFG_IDX_W'($urandom_range(rsbp_pkg::CFG_SCISSOR_BOTTOM + 1,
                                                          (1 << rsbp_pkg::CFG_IDX_W) - 1)),
                      $urandom);
        cur_setting = s;
        n_settings++;
    endtask

    task automatic send_pixel(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                              input logic [rsbp_pkg::PIX_W-1:0] dst, input logic cov,
                              input logic known, input t_pixel_write typed);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_pixel_x = x;
        i_pixel_y = y;
        i_dst_pixel = dst;
        i_covered = cov;
        exp_known = known;
        exp_typed = typed;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        n_sent++;
    endtask

    function automatic t_draw_setting random_setting();
        t_draw_setting                s;
        logic [rsbp_pkg::ALPHA_W-1:0] code;
        int                           lo;
        case ($urandom_range(0, 4))
            0: code = rsbp_pkg::ALPHA_DARK1;
            1: code = rsbp_pkg::ALPHA_DARK2;
            2: code = rsbp_pkg::ALPHA_DARK3;
            3: code = rsbp_pkg::ALPHA_DARK4;
            default: code = rsbp_pkg::ALPHA_OPAQUE;
        endcase
        case ($urandom_range(0, 5))
            0: s.fill = {5'd0, 3'($urandom), 5'd0, 3'($urandom), 5'd0, 3'($urandom), code};
            1: s.fill = {24'($urandom), rsbp_pkg::ALPHA_OPAQUE};
            2: s.fill = {24'($urandom), rsbp_pkg::ALPHA_CLEAR};
            3: s.fill = {5'd0, 3'($urandom), 5'd0, 3'($urandom), 5'd0, 3'($urandom),
                         8'($urandom)};
            default: s.fill = $urandom;
        endcase
        case ($urandom_range(0, 5))
            0, 1, 2: begin
                lo = $urandom_range(0, 1024);
                s.left = lo;
                s.right = $urandom_range(lo, 1024);
                lo = $urandom_range(0, 1024);
                s.top = lo;
                s.bottom = $urandom_range(lo, 1024);
            end
            3: begin
                s.left = 0;
                s.top = 0;
                s.right = 1024;
                s.bottom = 1024;
            end
            4: begin
                s.left = $urandom_range(0, 2047);
                s.top = $urandom_range(0, 2047);
                s.right = $urandom_range(0, 2047);
                s.bottom = $urandom_range(0, 2047);
            end
            default: begin
                s.left = $urandom;
                s.top = $urandom;
                s.right = $urandom;
                s.bottom = $urandom;
            end
        endcase
        return s;
    endfunction

    // Coordinate within two of either box limit, to hit the inclusive/exclusive edges
    function automatic logic [COORD_BITS-1:0] near_limit(input logic [31:0] lo,
                                                         input logic [31:0] hi);
        int b;
        b = ($urandom_range(0, 1) ? int'(lo[SCI_W-1:0]) : int'(hi[SCI_W-1:0])) +
            int'($urandom_range(0, 4)) - 2;
        if (b < 0)
            b = 0;
        if (b > COORD_MAX)
            b = COORD_MAX;
        return COORD_BITS'(b);
    endfunction

    initial begin
        logic [COORD_BITS-1:0] x, y;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            program_setting(DIRECTED[i].setup);
            send_pixel(DIRECTED[i].x, DIRECTED[i].y, DIRECTED[i].dst, DIRECTED[i].cov,
                       DIRECTED[i].known, '{DIRECTED[i].exp_pixel, DIRECTED[i].exp_we});
        end

        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 77 : 0;
            sink_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 20 : 0;
            for (int g = 0; g < GROUPS; g++) begin
                program_setting(random_setting());
                for (int n = 0; n < GROUP_LEN; n++) begin
                    x = $urandom_range(0, 1) ? COORD_BITS'($urandom)
                                             : near_limit(cur_setting.left, cur_setting.right);
                    y = $urandom_range(0, 1) ? COORD_BITS'($urandom)
                                             : near_limit(cur_setting.top, cur_setting.bottom);
                    send_pixel(x, y, rsbp_pkg::PIX_W'($urandom), $urandom_range(0, 3) != 0,
                               1'b0, '0);
                end
            end
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (pending_pixels.size() != 0)
            n_errors++;

        $display("Run covered %0d pixel transactions (%0d written back) across %0d register setups",
                 n_sent, n_written, n_settings);
        $display("Mismatches seen: %0d", n_errors);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout: %0d sent, %0d returned", n_sent, n_done);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
